// ----- sv/ptp_pkg.sv -----
// Package for the plane-through-three-points core.
// Holds the fixed field widths, default parameter values and the stage control struct.
`default_nettype none
package ptp_pkg;
    localparam int IN_BITS         = 16;
    localparam int SLOPE_BITS      = 50;
    localparam int OFFSET_BITS     = 64;
    localparam int COORD_BITS_DEF  = 16;
    localparam int FRAC_BITS_DEF   = 16;

    // Control bits that travel with every item through the pipeline.
    typedef struct packed {
        logic valid;
        logic zero;
        logic neg_a;
        logic neg_b;
    } t_ctl;
endpackage
`default_nettype wire

// ----- sv/ptp_front.sv -----
// Front end of the plane core: edge vectors, cross products, numerators and magnitudes.
// Four register stages; depends on ptp_pkg.
`default_nettype none
module ptp_front #(
    parameter int COORD_BITS = 16,
    parameter int NW         = 2 * COORD_BITS + 3
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_en,
    input  wire logic                       i_valid,
    input  wire logic [ptp_pkg::IN_BITS-1:0] i_p_x,
    input  wire logic [ptp_pkg::IN_BITS-1:0] i_p_y,
    input  wire logic [ptp_pkg::IN_BITS-1:0] i_p_z,
    input  wire logic [ptp_pkg::IN_BITS-1:0] i_q_x,
    input  wire logic [ptp_pkg::IN_BITS-1:0] i_q_y,
    input  wire logic [ptp_pkg::IN_BITS-1:0] i_q_z,
    input  wire logic [ptp_pkg::IN_BITS-1:0] i_r_x,
    input  wire logic [ptp_pkg::IN_BITS-1:0] i_r_y,
    input  wire logic [ptp_pkg::IN_BITS-1:0] i_r_z,
    output ptp_pkg::t_ctl                   o_ctl,
    output logic [NW-1:0]                   o_na,
    output logic [NW-1:0]                   o_nb,
    output logic [NW-1:0]                   o_d,
    output logic [COORD_BITS-1:0]           o_px,
    output logic [COORD_BITS-1:0]           o_py,
    output logic [COORD_BITS-1:0]           o_pz
);
    import ptp_pkg::*;

    localparam int C  = COORD_BITS;
    localparam int PW = 2 * C + 2;

    logic [C-1:0] w_px, w_py, w_pz, w_qx, w_qy, w_qz, w_rx, w_ry, w_rz;

    // Stage 1: differences.
    logic                r1_v;
    logic signed [C:0]   r1_ux, r1_uy, r1_uz, r1_vx, r1_vy, r1_vz;
    logic [C-1:0]        r1_px, r1_py, r1_pz;
    // Stage 2: products.
    logic                r2_v;
    logic signed [PW-1:0] r2_uzvy, r2_uyvz, r2_uxvz, r2_uzvx, r2_uxvy, r2_uyvx;
    logic [C-1:0]        r2_px, r2_py, r2_pz;
    // Stage 3: signed numerators and denominator.
    logic                r3_v;
    logic signed [NW-1:0] r3_na, r3_nb, r3_den;
    logic [C-1:0]        r3_px, r3_py, r3_pz;

    logic signed [PW-1:0] w_uzvy, w_uyvz, w_uxvz, w_uzvx, w_uxvy, w_uyvx;

    function automatic logic [C-1:0] f_coord(input logic [IN_BITS-1:0] v);
        logic [C+IN_BITS-1:0] t;
        t = {{C{1'b0}}, v};
        f_coord = t[C-1:0];
    endfunction

    function automatic logic [NW-1:0] f_abs(input logic signed [NW-1:0] v);
        f_abs = v[NW-1] ? NW'(-v) : NW'(v);
    endfunction

    assign w_px = f_coord(i_p_x);
    assign w_py = f_coord(i_p_y);
    assign w_pz = f_coord(i_p_z);
    assign w_qx = f_coord(i_q_x);
    assign w_qy = f_coord(i_q_y);
    assign w_qz = f_coord(i_q_z);
    assign w_rx = f_coord(i_r_x);
    assign w_ry = f_coord(i_r_y);
    assign w_rz = f_coord(i_r_z);

    assign w_uzvy = r1_uz * r1_vy;
    assign w_uyvz = r1_uy * r1_vz;
    assign w_uxvz = r1_ux * r1_vz;
    assign w_uzvx = r1_uz * r1_vx;
    assign w_uxvy = r1_ux * r1_vy;
    assign w_uyvx = r1_uy * r1_vx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v      <= 1'b0;
            r2_v      <= 1'b0;
            r3_v      <= 1'b0;
            o_ctl.valid <= 1'b0;
        end else if (i_en) begin
            r1_v      <= i_valid;
            r2_v      <= r1_v;
            r3_v      <= r2_v;
            o_ctl.valid <= r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_ux <= $signed({1'b0, w_qx}) - $signed({1'b0, w_px});
            r1_uy <= $signed({1'b0, w_qy}) - $signed({1'b0, w_py});
            r1_uz <= $signed({1'b0, w_qz}) - $signed({1'b0, w_pz});
            r1_vx <= $signed({1'b0, w_rx}) - $signed({1'b0, w_px});
            r1_vy <= $signed({1'b0, w_ry}) - $signed({1'b0, w_py});
            r1_vz <= $signed({1'b0, w_rz}) - $signed({1'b0, w_pz});
            r1_px <= w_px;
            r1_py <= w_py;
            r1_pz <= w_pz;

            r2_uzvy <= w_uzvy;
            r2_uyvz <= w_uyvz;
            r2_uxvz <= w_uxvz;
            r2_uzvx <= w_uzvx;
            r2_uxvy <= w_uxvy;
            r2_uyvx <= w_uyvx;
            r2_px   <= r1_px;
            r2_py   <= r1_py;
            r2_pz   <= r1_pz;

            r3_na  <= NW'(r2_uzvy) - NW'(r2_uyvz);
            r3_nb  <= NW'(r2_uxvz) - NW'(r2_uzvx);
            r3_den <= NW'(r2_uxvy) - NW'(r2_uyvx);
            r3_px  <= r2_px;
            r3_py  <= r2_py;
            r3_pz  <= r2_pz;

            o_ctl.zero  <= (r3_den == '0);
            o_ctl.neg_a <= r3_na[NW-1] ^ r3_den[NW-1];
            o_ctl.neg_b <= r3_nb[NW-1] ^ r3_den[NW-1];
            o_na <= f_abs(r3_na);
            o_nb <= f_abs(r3_nb);
            o_d  <= f_abs(r3_den);
            o_px <= r3_px;
            o_py <= r3_py;
            o_pz <= r3_pz;
        end
    end
endmodule
`default_nettype wire

// ----- sv/ptp_cell.sv -----
// One cell of the restoring divider chain: produces one quotient bit for both slopes.
// Depends on ptp_pkg for the control struct.
`default_nettype none
module ptp_cell #(
    parameter int NW         = 35,
    parameter int QW         = 51,
    parameter int COORD_BITS = 16
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_en,
    input  ptp_pkg::t_ctl               i_ctl,
    input  wire logic [NW-1:0]          i_d,
    input  wire logic [NW-1:0]          i_rem_a,
    input  wire logic [QW-1:0]          i_qd_a,
    input  wire logic [NW-1:0]          i_rem_b,
    input  wire logic [QW-1:0]          i_qd_b,
    input  wire logic [COORD_BITS-1:0]  i_px,
    input  wire logic [COORD_BITS-1:0]  i_py,
    input  wire logic [COORD_BITS-1:0]  i_pz,
    output ptp_pkg::t_ctl               o_ctl,
    output logic [NW-1:0]               o_d,
    output logic [NW-1:0]               o_rem_a,
    output logic [QW-1:0]               o_qd_a,
    output logic [NW-1:0]               o_rem_b,
    output logic [QW-1:0]               o_qd_b,
    output logic [COORD_BITS-1:0]       o_px,
    output logic [COORD_BITS-1:0]       o_py,
    output logic [COORD_BITS-1:0]       o_pz
);
    import ptp_pkg::*;

    logic [NW:0]   w_try_a, w_try_b, w_sub_a, w_sub_b;
    logic          w_ge_a, w_ge_b;

    // The dividend bits leave the top of qd while quotient bits enter at the bottom.
    assign w_try_a = {i_rem_a, i_qd_a[QW-1]};
    assign w_try_b = {i_rem_b, i_qd_b[QW-1]};
    assign w_sub_a = w_try_a - {1'b0, i_d};
    assign w_sub_b = w_try_b - {1'b0, i_d};
    assign w_ge_a  = (w_try_a >= {1'b0, i_d});
    assign w_ge_b  = (w_try_b >= {1'b0, i_d});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_ctl.valid <= 1'b0;
        end else if (i_en) begin
            o_ctl.valid <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_ctl.zero  <= i_ctl.zero;
            o_ctl.neg_a <= i_ctl.neg_a;
            o_ctl.neg_b <= i_ctl.neg_b;
            o_d     <= i_d;
            o_rem_a <= w_ge_a ? w_sub_a[NW-1:0] : w_try_a[NW-1:0];
            o_rem_b <= w_ge_b ? w_sub_b[NW-1:0] : w_try_b[NW-1:0];
            o_qd_a  <= {i_qd_a[QW-2:0], w_ge_a};
            o_qd_b  <= {i_qd_b[QW-2:0], w_ge_b};
            o_px    <= i_px;
            o_py    <= i_py;
            o_pz    <= i_pz;
        end
    end
endmodule
`default_nettype wire

// ----- sv/ptp_back.sv -----
// Back end of the plane core: signs and clamps the slopes, then forms the saturated offset.
// Two register stages and a combinational final sum; depends on ptp_pkg.
`default_nettype none
module ptp_back #(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 16,
    parameter int QW         = 51
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_en,
    input  ptp_pkg::t_ctl                          i_ctl,
    input  wire logic [QW-1:0]                     i_qa,
    input  wire logic [QW-1:0]                     i_qb,
    input  wire logic [COORD_BITS-1:0]             i_px,
    input  wire logic [COORD_BITS-1:0]             i_py,
    input  wire logic [COORD_BITS-1:0]             i_pz,
    output logic                                   o_valid,
    output logic signed [ptp_pkg::SLOPE_BITS-1:0]  o_slope_x,
    output logic signed [ptp_pkg::SLOPE_BITS-1:0]  o_slope_y,
    output logic signed [ptp_pkg::OFFSET_BITS-1:0] o_offset,
    output logic                                   o_degenerate,
    output logic                                   o_offset_saturated
);
    import ptp_pkg::*;

    localparam int C    = COORD_BITS;
    localparam int SW   = SLOPE_BITS;
    localparam int OB   = OFFSET_BITS;
    localparam int CW   = ((QW > SW) ? QW : SW) + 1;
    localparam int PW   = SW + C + 1;
    localparam int SUMW = SW + C + 3;
    localparam int EXW  = (SUMW > OB) ? SUMW : OB;

    logic                 r1_v, r1_zero;
    logic signed [SW-1:0] r1_a, r1_b;
    logic [C-1:0]         r1_px, r1_py, r1_pz;

    logic                 r2_v, r2_zero;
    logic signed [SW-1:0] r2_a, r2_b;
    logic signed [PW-1:0] r2_pa, r2_pb;
    logic [C+FRAC_BITS-1:0] r2_pzf;

    logic signed [PW-1:0]   w_pa, w_pb;
    logic signed [SUMW-1:0] w_sum;
    logic signed [EXW-1:0]  w_ext;
    logic                   w_ovf;
    logic [OB-1:0]          w_sat;

    // Truncated magnitude to signed slope, clamped to the slope range.
    function automatic logic [SW-1:0] f_clamp(input logic [QW-1:0] q, input logic neg);
        logic [CW-1:0] qe;
        logic [CW-1:0] lim;
        logic [CW-1:0] m;
        qe  = CW'(q);
        lim = CW'(1) << (SW - 1);
        if (neg) begin
            m = (qe > lim) ? lim : qe;
            m = -m;
        end else begin
            m = (qe >= lim) ? lim - CW'(1) : qe;
        end
        f_clamp = m[SW-1:0];
    endfunction

    assign w_pa = r1_a * $signed({1'b0, r1_px});
    assign w_pb = r1_b * $signed({1'b0, r1_py});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
        end else if (i_en) begin
            r1_v <= i_ctl.valid;
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_zero <= i_ctl.zero;
            r1_a    <= i_ctl.zero ? '0 : $signed(f_clamp(i_qa, i_ctl.neg_a));
            r1_b    <= i_ctl.zero ? '0 : $signed(f_clamp(i_qb, i_ctl.neg_b));
            r1_px   <= i_px;
            r1_py   <= i_py;
            r1_pz   <= i_pz;

            r2_zero <= r1_zero;
            r2_a    <= r1_a;
            r2_b    <= r1_b;
            r2_pa   <= w_pa;
            r2_pb   <= w_pb;
            r2_pzf  <= {r1_pz, {FRAC_BITS{1'b0}}};
        end
    end

    assign w_sum = $signed({{(SUMW - C - FRAC_BITS){1'b0}}, r2_pzf})
                   - SUMW'(r2_pa) - SUMW'(r2_pb);
    assign w_ext = EXW'(w_sum);
    assign w_ovf = (w_ext[EXW-1:OB-1] != {(EXW - OB + 1){w_ext[OB-1]}});
    assign w_sat = w_ext[EXW-1] ? {1'b1, {(OB-1){1'b0}}} : {1'b0, {(OB-1){1'b1}}};

    assign o_valid            = r2_v;
    assign o_slope_x          = r2_a;
    assign o_slope_y          = r2_b;
    assign o_degenerate       = r2_zero;
    assign o_offset_saturated = !r2_zero && w_ovf;
    assign o_offset           = r2_zero ? '0 : (w_ovf ? $signed(w_sat) : $signed(w_ext[OB-1:0]));
endmodule
`default_nettype wire

// ----- sv/plane_through_three_points_core.sv -----
// Plane through three points: z = a*x + b*y + c, a and b truncated toward zero.
// An input transfer passes the front end, the divider chain and the back end, then the output register.
// Throughput: one item per cycle while the skid entry is empty; the divider is a chain of one cell per quotient bit.
// An output register plus one skid entry keep input transfers going while a result waits.
// Reset clears only the valid bits of the stages, the output and the skid entry; there is no clearing pass.
`default_nettype none
module plane_through_three_points_core #(
    parameter int COORD_BITS = ptp_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = ptp_pkg::FRAC_BITS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    output logic                                   o_stall,
    input  wire logic [ptp_pkg::IN_BITS-1:0]       i_p_x,
    input  wire logic [ptp_pkg::IN_BITS-1:0]       i_p_y,
    input  wire logic [ptp_pkg::IN_BITS-1:0]       i_p_z,
    input  wire logic [ptp_pkg::IN_BITS-1:0]       i_q_x,
    input  wire logic [ptp_pkg::IN_BITS-1:0]       i_q_y,
    input  wire logic [ptp_pkg::IN_BITS-1:0]       i_q_z,
    input  wire logic [ptp_pkg::IN_BITS-1:0]       i_r_x,
    input  wire logic [ptp_pkg::IN_BITS-1:0]       i_r_y,
    input  wire logic [ptp_pkg::IN_BITS-1:0]       i_r_z,
    output logic                                   o_valid,
    input  wire logic                              i_stall,
    output logic signed [ptp_pkg::SLOPE_BITS-1:0]  o_slope_x,
    output logic signed [ptp_pkg::SLOPE_BITS-1:0]  o_slope_y,
    output logic signed [ptp_pkg::OFFSET_BITS-1:0] o_offset,
    output logic                                   o_degenerate,
    output logic                                   o_offset_saturated
);
    import ptp_pkg::*;

    localparam int C  = COORD_BITS;
    localparam int NW = 2 * C + 3;
    localparam int QW = NW + FRAC_BITS;

    logic w_en;

    t_ctl         w_ctl  [0:QW];
    logic [NW-1:0] w_d    [0:QW];
    logic [NW-1:0] w_rem_a[0:QW];
    logic [NW-1:0] w_rem_b[0:QW];
    logic [QW-1:0] w_qd_a [0:QW];
    logic [QW-1:0] w_qd_b [0:QW];
    logic [C-1:0]  w_px   [0:QW];
    logic [C-1:0]  w_py   [0:QW];
    logic [C-1:0]  w_pz   [0:QW];
    logic [NW-1:0] w_na, w_nb;

    logic                   w_bv, w_bdeg, w_bsat;
    logic signed [SLOPE_BITS-1:0]  w_bsx, w_bsy;
    logic signed [OFFSET_BITS-1:0] w_boff;

    logic                   r_ov, r_sk_v;
    logic signed [SLOPE_BITS-1:0]  r_sk_sx, r_sk_sy;
    logic signed [OFFSET_BITS-1:0] r_sk_off;
    logic                   r_sk_deg, r_sk_sat;
    logic signed [SLOPE_BITS-1:0]  r_o_sx, r_o_sy;
    logic signed [OFFSET_BITS-1:0] r_o_off;
    logic                   r_o_deg, r_o_sat;

    logic w_new, w_take, w_blocked;

    // The whole pipeline advances unless the skid entry is occupied.
    assign w_en    = !r_sk_v;
    assign o_stall = r_sk_v;

    ptp_front #(.COORD_BITS(C), .NW(NW)) u_front (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (w_en),
        .i_valid(i_valid),
        .i_p_x  (i_p_x),
        .i_p_y  (i_p_y),
        .i_p_z  (i_p_z),
        .i_q_x  (i_q_x),
        .i_q_y  (i_q_y),
        .i_q_z  (i_q_z),
        .i_r_x  (i_r_x),
        .i_r_y  (i_r_y),
        .i_r_z  (i_r_z),
        .o_ctl  (w_ctl[0]),
        .o_na   (w_na),
        .o_nb   (w_nb),
        .o_d    (w_d[0]),
        .o_px   (w_px[0]),
        .o_py   (w_py[0]),
        .o_pz   (w_pz[0])
    );

    // The dividend enters the chain already scaled by the fraction bits.
    assign w_rem_a[0] = '0;
    assign w_rem_b[0] = '0;
    assign w_qd_a[0]  = {w_na, {FRAC_BITS{1'b0}}};
    assign w_qd_b[0]  = {w_nb, {FRAC_BITS{1'b0}}};

    for (genvar g = 0; g < QW; g++) begin : g_cell
        ptp_cell #(.NW(NW), .QW(QW), .COORD_BITS(C)) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (w_en),
            .i_ctl  (w_ctl[g]),
            .i_d    (w_d[g]),
            .i_rem_a(w_rem_a[g]),
            .i_qd_a (w_qd_a[g]),
            .i_rem_b(w_rem_b[g]),
            .i_qd_b (w_qd_b[g]),
            .i_px   (w_px[g]),
            .i_py   (w_py[g]),
            .i_pz   (w_pz[g]),
            .o_ctl  (w_ctl[g+1]),
            .o_d    (w_d[g+1]),
            .o_rem_a(w_rem_a[g+1]),
            .o_qd_a (w_qd_a[g+1]),
            .o_rem_b(w_rem_b[g+1]),
            .o_qd_b (w_qd_b[g+1]),
            .o_px   (w_px[g+1]),
            .o_py   (w_py[g+1]),
            .o_pz   (w_pz[g+1])
        );
    end

    ptp_back #(.COORD_BITS(C), .FRAC_BITS(FRAC_BITS), .QW(QW)) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_en              (w_en),
        .i_ctl             (w_ctl[QW]),
        .i_qa              (w_qd_a[QW]),
        .i_qb              (w_qd_b[QW]),
        .i_px              (w_px[QW]),
        .i_py              (w_py[QW]),
        .i_pz              (w_pz[QW]),
        .o_valid           (w_bv),
        .o_slope_x         (w_bsx),
        .o_slope_y         (w_bsy),
        .o_offset          (w_boff),
        .o_degenerate      (w_bdeg),
        .o_offset_saturated(w_bsat)
    );

    assign w_new     = w_bv && w_en;
    assign w_take    = r_ov && !i_stall;
    assign w_blocked = r_ov && i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov   <= 1'b0;
            r_sk_v <= 1'b0;
        end else if (r_sk_v) begin
            if (w_take) begin
                r_sk_v <= 1'b0;
            end
        end else if (w_new) begin
            if (w_blocked) begin
                r_sk_v <= 1'b1;
            end else begin
                r_ov <= 1'b1;
            end
        end else if (w_take) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_sk_v && w_take) begin
            r_o_sx  <= r_sk_sx;
            r_o_sy  <= r_sk_sy;
            r_o_off <= r_sk_off;
            r_o_deg <= r_sk_deg;
            r_o_sat <= r_sk_sat;
        end else if (w_new && !w_blocked) begin
            r_o_sx  <= w_bsx;
            r_o_sy  <= w_bsy;
            r_o_off <= w_boff;
            r_o_deg <= w_bdeg;
            r_o_sat <= w_bsat;
        end
        if (w_new && w_blocked) begin
            r_sk_sx  <= w_bsx;
            r_sk_sy  <= w_bsy;
            r_sk_off <= w_boff;
            r_sk_deg <= w_bdeg;
            r_sk_sat <= w_bsat;
        end
    end

    assign o_valid            = r_ov;
    assign o_slope_x          = r_o_sx;
    assign o_slope_y          = r_o_sy;
    assign o_offset           = r_o_off;
    assign o_degenerate       = r_o_deg;
    assign o_offset_saturated = r_o_sat;

`ifndef SYNTHESIS
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sk_v |-> r_ov)
        else $error("skid entry holds a result while the output register is empty");

    a_skid_fill_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_sk_v) |-> $past(i_stall))
        else $error("skid entry filled without a stalled output");

    a_degenerate_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_degenerate) |->
            (o_slope_x == '0 && o_slope_y == '0 && o_offset == '0 && !o_offset_saturated))
        else $error("degenerate result carries nonzero coefficients");

    a_out_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sk_v && i_stall) |=> (r_sk_v && $stable(r_sk_off) && $stable(r_sk_sx)))
        else $error("skid entry changed while the output was stalled");
`endif
endmodule
`default_nettype wire

// ----- bench/tb_plane_through_three_points_core.sv -----
// Testbench for plane_through_three_points_core: directed and random triangles, checked
// against an in-bench plane predictor. Depends on ptp_pkg and the core RTL only.
`timescale 1ns / 1ps
module tb_plane_through_three_points_core;
    import ptp_pkg::*;

    localparam int CB = COORD_BITS_DEF;
    localparam int FB = FRAC_BITS_DEF;

    typedef struct packed {
        logic signed [SLOPE_BITS-1:0]  sx;
        logic signed [SLOPE_BITS-1:0]  sy;
        logic signed [OFFSET_BITS-1:0] off;
        logic                          degen;
        logic                          sat;
    } plane_t;

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_valid = 0;
    logic i_stall = 0;
    logic [IN_BITS-1:0] px = 0, py = 0, pz = 0, qx = 0, qy = 0, qz = 0, rx = 0, ry = 0, rz = 0;
    logic o_stall, o_valid, o_degenerate, o_offset_saturated;
    logic signed [SLOPE_BITS-1:0] o_slope_x, o_slope_y;
    logic signed [OFFSET_BITS-1:0] o_offset;

    plane_t planes_due[$];
    int errors = 0;
    int n_sent = 0, n_degen = 0, n_sat = 0;
    bit rx_quiet = 0;      // no receiver idling in the last part
    int hold_cycles = 0;   // long receiver hold-off, counted down by the stall process

    plane_through_three_points_core dut (
        .i_clk, .i_rst_n, .i_valid, .o_stall,
        .i_p_x(px), .i_p_y(py), .i_p_z(pz), .i_q_x(qx), .i_q_y(qy), .i_q_z(qz),
        .i_r_x(rx), .i_r_y(ry), .i_r_z(rz),
        .o_valid, .i_stall, .o_slope_x, .o_slope_y, .o_offset, .o_degenerate,
        .o_offset_saturated
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #40_000_000;
        $display("** plane_through_three_points_core: FAILED **");
        $finish;
    end

    // Truncating division of num * 2^FB by den, clamped to the slope range.
    function automatic logic signed [SLOPE_BITS-1:0] slope_of(longint num, longint den);
        logic [127:0] n, d, q;
        logic [127:0] lim;
        n = (num < 0) ? 128'(-num) : 128'(num);
        d = (den < 0) ? 128'(-den) : 128'(den);
        lim = 128'd1 << (SLOPE_BITS - 1);
        q = (n << FB) / d;
        if (q > lim) q = lim;
        if ((num < 0) != (den < 0)) return -q[SLOPE_BITS-1:0];
        if (q >= lim) q = lim - 1;
        return q[SLOPE_BITS-1:0];
    endfunction

    function automatic plane_t plane_of(logic [IN_BITS-1:0] ax, ay, az, bx, by, bz,
                                        cx, cy, cz);
        plane_t res;
        longint x0, y0, z0, ux, uy, uz, vx, vy, vz, den;
        logic signed [129:0] c;
        x0 = longint'(ax[CB-1:0]); y0 = longint'(ay[CB-1:0]); z0 = longint'(az[CB-1:0]);
        ux = longint'(bx[CB-1:0]) - x0; uy = longint'(by[CB-1:0]) - y0;
        uz = longint'(bz[CB-1:0]) - z0;
        vx = longint'(cx[CB-1:0]) - x0; vy = longint'(cy[CB-1:0]) - y0;
        vz = longint'(cz[CB-1:0]) - z0;
        den = ux * vy - uy * vx;
        res = '0;
        if (den == 0) begin
            res.degen = 1'b1;
            return res;
        end
        res.sx = slope_of(uz * vy - uy * vz, den);
        res.sy = slope_of(ux * vz - uz * vx, den);
        c = (130'(z0) <<< FB) - 130'(res.sx) * 130'(x0) - 130'(res.sy) * 130'(y0);
        if (c > 130'sh7FFF_FFFF_FFFF_FFFF) begin
            res.off = {1'b0, {63{1'b1}}}; res.sat = 1'b1;
        end else if (c < -130'sh8000_0000_0000_0000) begin
            res.off = {1'b1, 63'b0}; res.sat = 1'b1;
        end else begin
            res.off = c[63:0];
        end
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        errors++;
        $display("%0t mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    endtask

    // Result checker; the receiver idling follows in the next process.
    always @(posedge i_clk) begin
        plane_t w;
        if (i_rst_n && o_valid && !i_stall) begin
            if (planes_due.size() == 0) begin
                report_mismatch("unexpected transfer", o_offset, 64'd0);
            end else begin
                w = planes_due.pop_front();
                if (o_slope_x !== w.sx) report_mismatch("slope_x", 64'(o_slope_x), 64'(w.sx));
                if (o_slope_y !== w.sy) report_mismatch("slope_y", 64'(o_slope_y), 64'(w.sy));
                if (o_offset !== w.off) report_mismatch("offset", o_offset, w.off);
                if (o_degenerate !== w.degen)
                    report_mismatch("degenerate", 64'(o_degenerate), 64'(w.degen));
                if (o_offset_saturated !== w.sat)
                    report_mismatch("offset_saturated", 64'(o_offset_saturated), 64'(w.sat));
            end
        end
    end

    initial begin
        int burst;
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                i_stall <= 1;
                hold_cycles--;
            end else if (!rx_quiet && $urandom_range(0, 7) == 0) begin
                burst = $urandom_range(1, 6);
                i_stall <= 1;
                repeat (burst - 1) @(negedge i_clk);
            end else begin
                i_stall <= 0;
            end
        end
    end

    // Offers one triangle and holds it until the transfer; the expectation is queued then.
    // Valid stays high afterwards so that the next call can follow without a gap.
    task automatic send_triangle(logic [IN_BITS-1:0] ax, ay, az, bx, by, bz, cx, cy, cz,
                                 bit gaps = 1);
        plane_t w;
        if (gaps && $urandom_range(0, 5) == 0) begin
            i_valid <= 0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        {px, py, pz, qx, qy, qz, rx, ry, rz} <= {ax, ay, az, bx, by, bz, cx, cy, cz};
        i_valid <= 1;
        w = plane_of(ax, ay, az, bx, by, bz, cx, cy, cz);
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        planes_due.push_back(w);
        n_sent++;
        if (w.degen) n_degen++;
        if (w.sat) n_sat++;
        @(negedge i_clk);
    endtask

    function automatic logic [IN_BITS-1:0] rnd16();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return 16'hFFFF;
            2: return IN_BITS'($urandom_range(0, 15));
            3: return IN_BITS'(16'hFFFF - $urandom_range(0, 15));
            default: return IN_BITS'($urandom);
        endcase
    endfunction

    task automatic test_directed();
        send_triangle(0, 0, 0, 0, 0, 0, 0, 0, 0);          // all points equal: collinear
        send_triangle(0, 0, 0, 1, 0, 0, 0, 1, 0);          // flat unit triangle
        send_triangle(0, 0, 0, 1, 0, 16'hFFFF, 0, 1, 16'hFFFF);
        send_triangle(16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 16'hFFFF, 0, 16'hFFFF, 0, 0);
        send_triangle(0, 0, 0, 5, 5, 7, 10, 10, 3);        // collinear in xy
        send_triangle(16'hFFFF, 0, 0, 16'hFFFF, 1, 16'hFFFF, 16'hFFFE, 0, 0); // steep slope
        send_triangle(0, 16'hFFFF, 0, 1, 16'hFFFF, 16'hFFFF, 0, 16'hFFFE, 16'hFFFF);
        send_triangle(16'hFFFF, 16'hFFFF, 0, 16'hFFFE, 16'hFFFF, 16'hFFFF,
                      16'hFFFF, 16'hFFFE, 16'hFFFF);       // large offset, may saturate
        send_triangle(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFE, 16'hFFFF, 0,
                      16'hFFFF, 16'hFFFE, 0);
        send_triangle(0, 0, 16'hFFFF, 16'hFFFF, 0, 0, 0, 16'hFFFF, 0);
        send_triangle(0, 0, 0, 3, 0, 1, 0, 3, 2);          // fractional slopes
        send_triangle(0, 0, 0, 16'hFFFF, 1, 1, 1, 16'hFFFF, 0);
        send_triangle(16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h8001, 0,
                      16'h8001, 16'h8001, 16'hFFFF);
    endtask

    task automatic test_random(int count, bit gaps);
        logic [IN_BITS-1:0] ax, ay, bx, by;
        repeat (count) begin
            if ($urandom_range(0, 9) == 0) begin
                // collinear: third point on the line through the first two
                ax = IN_BITS'($urandom_range(0, 1000)); ay = IN_BITS'($urandom_range(0, 1000));
                bx = IN_BITS'(ax + $urandom_range(0, 100));
                by = IN_BITS'(ay + $urandom_range(0, 100));
                send_triangle(ax, ay, rnd16(), bx, by, rnd16(),
                              IN_BITS'(2 * bx - ax), IN_BITS'(2 * by - ay), rnd16(), gaps);
            end else if ($urandom_range(0, 3) == 0) begin
                // near neighbours, as in a mesh, with random heights
                ax = rnd16(); ay = rnd16();
                send_triangle(ax, ay, rnd16(), IN_BITS'(ax + $urandom_range(0, 3) - 1),
                              IN_BITS'(ay + $urandom_range(0, 3)), rnd16(),
                              IN_BITS'(ax + $urandom_range(0, 3)),
                              IN_BITS'(ay + $urandom_range(0, 3) - 1),
                              rnd16(), gaps);
            end else begin
                send_triangle(rnd16(), rnd16(), rnd16(), rnd16(), rnd16(), rnd16(),
                              rnd16(), rnd16(), rnd16(), gaps);
            end
        end
    endtask

    // Receiver holds off long enough that the pipeline fills and stalls its input.
    task automatic test_backpressure();
        hold_cycles = 200;
        test_random(120, 0);
    endtask

    initial begin
        int waited;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);
        test_directed();
        test_random(700, 1);
        test_backpressure();
        rx_quiet = 1;
        test_random(450, 0);
        i_valid <= 0;
        waited = 0;
        while (planes_due.size() != 0 && waited < 100000) begin
            @(negedge i_clk);
            waited++;
        end
        repeat (80) @(negedge i_clk);
        $display("Sent %0d triangles: %0d collinear, %0d with clamped offset.",
                 n_sent, n_degen, n_sat);
        if (errors == 0 && planes_due.size() == 0) begin
            $display("** plane_through_three_points_core: PASSED **");
        end else begin
            $display("** plane_through_three_points_core: FAILED **");
        end
        $finish;
    end
endmodule

// ----- sim.f -----
sv/ptp_pkg.sv
sv/ptp_front.sv
sv/ptp_cell.sv
sv/ptp_back.sv
sv/plane_through_three_points_core.sv
bench/tb_plane_through_three_points_core.sv
